/* hdl/uere_pkg.sv */
`timescale 1ns / 1ps

package uere_pkg;

    // default channel count of the ranger
    localparam int NUM_CHANNELS_DEFAULT = 4;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [2:0] REG_SETTLE_LIMIT  = 3'd0;
    localparam logic [2:0] REG_TRIGGER_TICKS = 3'd1;
    localparam logic [2:0] REG_ECHO_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_SCALE_Q16     = 3'd3;
    localparam logic [2:0] REG_MIN_DISTANCE  = 3'd4;
    localparam logic [2:0] REG_MAX_DISTANCE  = 3'd5;
    localparam logic [2:0] REG_ALPHA_Q8      = 3'd6;

    // configuration reset values
    localparam logic [15:0] SETTLE_LIMIT_RST  = 16'd1000;
    localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
    localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30000;
    localparam logic [15:0] SCALE_Q16_RST     = 16'd17983;
    localparam logic [14:0] MIN_DISTANCE_RST  = 15'd32;
    localparam logic [14:0] MAX_DISTANCE_RST  = 15'd6400;
    localparam logic [8:0]  ALPHA_Q8_RST      = 9'd77;

    // result status codes
    localparam logic [2:0] ST_NONE   = 3'd0;
    localparam logic [2:0] ST_VALID  = 3'd1;
    localparam logic [2:0] ST_NOECHO = 3'd2;
    localparam logic [2:0] ST_LONG   = 3'd3;
    localparam logic [2:0] ST_RANGE  = 3'd4;

    // full weight of the average in Q8
    localparam logic [8:0] ALPHA_ONE = 9'd256;

    typedef struct packed {
        logic [15:0] settle_limit;
        logic [7:0]  trigger_ticks;
        logic [15:0] echo_timeout;
        logic [15:0] scale_q16;
        logic [14:0] min_distance;
        logic [14:0] max_distance;
        logic [8:0]  alpha_q8;
    } cfg_t;

    // one classified tick handed from front to back
    typedef struct packed {
        logic        trig;
        logic        busy;
        logic [2:0]  status;
        logic [1:0]  chan;
        logic        finish;
        logic [15:0] width;
    } q_entry_t;

    // one result beat
    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic [2:0]  status;
        logic [1:0]  result_channel;
        logic [14:0] raw_distance;
        logic [14:0] filtered_distance;
    } out_t;

endpackage

/* hdl/uere_front.sv */
`timescale 1ns / 1ps

module uere_front
    import uere_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     start_req,
    input  logic [1:0] channel,
    input  logic     echo_level,
    input  logic     q_full,
    output logic     push,
    output q_entry_t push_data
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SETTLE = 3'd1;
    localparam logic [2:0] PH_TRIG   = 3'd2;
    localparam logic [2:0] PH_RISE   = 3'd3;
    localparam logic [2:0] PH_WIDTH  = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [1:0]  chan_reg, chan_next;
    logic [15:0] cnt_inc;
    logic [2:0]  st;
    logic        fin;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;
    assign cnt_inc  = cnt_reg + 16'd1;

    // tick sequencer
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        chan_next  = chan_reg;
        st         = ST_NONE;
        fin        = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req && (int'(channel) < NUM_CHANNELS))
                begin
                    chan_next  = channel;
                    cnt_next   = 16'd0;
                    phase_next = PH_SETTLE;
                end
            end
            PH_SETTLE:
            begin
                if (!echo_level || (cnt_reg >= cfg.settle_limit))
                begin
                    cnt_next   = 16'd0;
                    phase_next = PH_TRIG;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_TRIG:
            begin
                if (cnt_inc >= {8'd0, cfg.trigger_ticks})
                begin
                    cnt_next   = 16'd0;
                    phase_next = PH_RISE;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_RISE:
            begin
                if (echo_level)
                begin
                    cnt_next   = 16'd1;
                    phase_next = PH_WIDTH;
                end
                else if (cnt_reg >= cfg.echo_timeout)
                begin
                    st = ST_NOECHO;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_WIDTH:
            begin
                if (echo_level)
                begin
                    if (cnt_reg >= cfg.echo_timeout)
                        st = ST_LONG;
                    else
                        cnt_next = cnt_inc;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        // any end of measurement returns to idle
        if ((st != ST_NONE) || fin)
        begin
            phase_next = PH_IDLE;
            cnt_next   = 16'd0;
        end
    end

    // entry for the back part
    always_comb
    begin
        push_data.trig   = (phase_next == PH_TRIG);
        push_data.busy   = (phase_next != PH_IDLE);
        push_data.status = st;
        push_data.chan   = chan_next;
        push_data.finish = fin;
        push_data.width  = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 16'd0;
            chan_reg  <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            chan_reg  <= chan_next;
        end
    end

endmodule

/* hdl/uere_queue.sv */
`timescale 1ns / 1ps

module uere_queue
    import uere_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_entry_t head,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_reg];

    // pointer and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

/* hdl/uere_back.sv */
`timescale 1ns / 1ps

module uere_back
    import uere_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  q_entry_t head,
    input  logic     empty,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output out_t     out_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_RANGE = 2'd1;
    localparam logic [1:0] B_BLEND = 2'd2;
    localparam logic [1:0] B_OUT   = 2'd3;

    logic [1:0]        bst_reg, bst_next;
    logic              out_valid_reg;
    out_t              out_reg, out_next;
    logic              out_load;
    logic              can_load;

    logic [NUM_CHANNELS-1:0] primed_reg;
    logic [14:0]       avg_reg [NUM_CHANNELS];
    logic              avg_we;
    logic [14:0]       avg_wdata;

    logic [31:0]       prod_reg;
    logic [1:0]        chan_reg;
    logic [14:0]       raw_reg;
    logic              ok_reg;
    logic [23:0]       new_reg, old_reg;

    logic [CH_W-1:0]   idx;
    logic [8:0]        alpha_sat, alpha_rest;
    logic [32:0]       dsum;
    logic [16:0]       scaled;
    logic              in_range;
    logic [24:0]       blend_sum;

    assign can_load   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;
    assign idx        = CH_W'(chan_reg);
    assign alpha_sat  = (cfg.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q8;
    assign alpha_rest = ALPHA_ONE - alpha_sat;

    // scale with round half up, then range check
    assign dsum     = {1'b0, prod_reg} + 33'd32768;
    assign scaled   = dsum[32:16];
    assign in_range = (scaled >= {2'b00, cfg.min_distance}) &&
                      (scaled <= {2'b00, cfg.max_distance});
    assign blend_sum = {1'b0, new_reg} + {1'b0, old_reg} + 25'd128;

    // back sequencer
    always_comb
    begin
        bst_next  = bst_reg;
        pop       = 1'b0;
        out_load  = 1'b0;
        avg_we    = 1'b0;
        avg_wdata = raw_reg;
        out_next.trigger_level     = head.trig;
        out_next.busy_res          = head.busy;
        out_next.status            = head.status;
        out_next.result_channel    = head.chan;
        out_next.raw_distance      = 15'd0;
        out_next.filtered_distance = 15'd0;
        unique case (bst_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    if (head.finish)
                    begin
                        pop      = 1'b1;
                        bst_next = B_RANGE;
                    end
                    else if (can_load)
                    begin
                        pop      = 1'b1;
                        out_load = 1'b1;
                    end
                end
            end
            B_RANGE:
            begin
                bst_next = B_BLEND;
            end
            B_BLEND:
            begin
                bst_next = B_OUT;
            end
            B_OUT:
            begin
                out_next.trigger_level  = 1'b0;
                out_next.busy_res       = 1'b0;
                out_next.result_channel = chan_reg;
                if (can_load)
                begin
                    out_load = 1'b1;
                    bst_next = B_IDLE;
                    if (!ok_reg)
                    begin
                        out_next.status = ST_RANGE;
                    end
                    else
                    begin
                        avg_we = 1'b1;
                        if (primed_reg[idx])
                            avg_wdata = blend_sum[22:8];
                        out_next.status            = ST_VALID;
                        out_next.raw_distance      = raw_reg;
                        out_next.filtered_distance = avg_wdata;
                    end
                end
            end
            default:
            begin
                bst_next = B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_reg       <= B_IDLE;
            out_valid_reg <= 1'b0;
            primed_reg    <= '0;
        end
        else
        begin
            bst_reg <= bst_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (avg_we)
                primed_reg[idx] <= 1'b1;
        end
    end

    // arithmetic datapath and result register
    always_ff @(posedge clk)
    begin
        if ((bst_reg == B_IDLE) && pop && head.finish)
        begin
            prod_reg <= 32'(head.width) * 32'(cfg.scale_q16);
            chan_reg <= head.chan;
        end
        if (bst_reg == B_RANGE)
        begin
            raw_reg <= scaled[14:0];
            ok_reg  <= in_range;
            new_reg <= 24'(alpha_sat) * 24'(scaled[14:0]);
        end
        if (bst_reg == B_BLEND)
            old_reg <= 24'(alpha_rest) * 24'(avg_reg[idx]);
        if (avg_we)
            avg_reg[idx] <= avg_wdata;
        if (out_load)
            out_reg <= out_next;
    end

endmodule

/* hdl/ultrasonic_echo_ranger_ema_core.sv */
`timescale 1ns / 1ps

// Ultrasonic echo ranger with a per-channel exponential average.
// Input channel (in_valid/in_ready): one beat per microsecond tick carrying
// start_req, channel and the sampled echo_level of the active sensor.
// Output channel (out_valid/out_ready): exactly one beat per input beat, in
// order, with the trigger drive, busy flag, status and, on a valid sample,
// the raw and averaged distance in sixteenths of a cm.
// A front sequencer times the settle, trigger, rise and width phases and takes
// one tick per cycle while the queue is not full; a four-entry queue feeds the
// back part. Ticks that do not end a width measurement pass through the queue
// into the output register. The tick that ends a width measurement goes
// through the back in steps: scale multiply, range check with the new-sample
// product, old-average product, then the blend and write.
// Throughput is one tick per cycle between measurements while nothing stalls;
// each completed width measurement holds the back in its range, blend and
// output steps; the queue absorbs this or, once full, in_ready goes low.
// When the receiver stalls, the output register holds its beat and the queue
// fills; in_ready drops once the queue is full.
// Reset puts the sequencer in idle, clears the queue and out_valid, marks all
// channel averages as unseeded and loads the configuration defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module ultrasonic_echo_ranger_ema_core
    import uere_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_req,
    input  logic [1:0]  channel,
    input  logic        echo_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        trigger_level,
    output logic        busy_res,
    output logic [2:0]  status,
    output logic [1:0]  result_channel,
    output logic [14:0] raw_distance,
    output logic [14:0] filtered_distance
);

    cfg_t     cfg_reg;
    logic     q_full, q_empty, q_push, q_pop;
    q_entry_t q_in, q_head;
    out_t     out_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_limit  <= SETTLE_LIMIT_RST;
            cfg_reg.trigger_ticks <= TRIGGER_TICKS_RST;
            cfg_reg.echo_timeout  <= ECHO_TIMEOUT_RST;
            cfg_reg.scale_q16     <= SCALE_Q16_RST;
            cfg_reg.min_distance  <= MIN_DISTANCE_RST;
            cfg_reg.max_distance  <= MAX_DISTANCE_RST;
            cfg_reg.alpha_q8      <= ALPHA_Q8_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETTLE_LIMIT:  cfg_reg.settle_limit  <= cfg_data;
                REG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= cfg_data[7:0];
                REG_ECHO_TIMEOUT:  cfg_reg.echo_timeout  <= cfg_data;
                REG_SCALE_Q16:     cfg_reg.scale_q16     <= cfg_data;
                REG_MIN_DISTANCE:  cfg_reg.min_distance  <= cfg_data[14:0];
                REG_MAX_DISTANCE:  cfg_reg.max_distance  <= cfg_data[14:0];
                REG_ALPHA_Q8:      cfg_reg.alpha_q8      <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    uere_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_req  (start_req),
        .channel    (channel),
        .echo_level (echo_level),
        .q_full     (q_full),
        .push       (q_push),
        .push_data  (q_in)
    );

    uere_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    uere_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // result beat fields
    assign trigger_level     = out_data.trigger_level;
    assign busy_res          = out_data.busy_res;
    assign status            = out_data.status;
    assign result_channel    = out_data.result_channel;
    assign raw_distance      = out_data.raw_distance;
    assign filtered_distance = out_data.filtered_distance;

endmodule
